// ===== design/arp_cache_with_aging_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH
`define ARP_CACHE_WITH_AGING_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ARPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/arpc_pkg.sv =====
package arpc_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 16;

	localparam logic [15:0] ETHER_ARP = 16'h0806;
	localparam logic [15:0] OP_REPLY  = 16'd2;
	localparam logic [15:0] AGE_RESET = 16'd6000;

	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_FRAME  = 1'b1;

	typedef enum logic [1:0] {
		CFG_OWN_IP    = 2'd0,
		CFG_OWN_MAC   = 2'd1,
		CFG_AGE_LIMIT = 2'd2
	} arpc_cfg_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} arpc_state_t;

	// Record that travels down the row of entry cells, one cell per cycle.
	typedef struct packed {
		logic        act;
		logic [31:0] ip;
		logic [31:0] now;
		logic        fresh;
		logic [47:0] mac;
		logic        match;
		logic        free;
		logic        old_any;
		logic [31:0] old_age;
	} arpc_scan_t;

	// Entry write broadcast to all cells.
	typedef struct packed {
		logic        en;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] stamp;
	} arpc_wr_t;

endpackage

// ===== design/arpc_cell.sv =====
module arpc_cell
	import arpc_pkg::*;
#(
	parameter int unsigned      IDX_W    = 4,
	parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      age_limit,
	input  arpc_wr_t         wr,
	input  logic [IDX_W-1:0] wr_idx,
	input  arpc_scan_t       scan_i,
	input  logic [IDX_W-1:0] match_idx_i,
	input  logic [IDX_W-1:0] free_idx_i,
	input  logic [IDX_W-1:0] old_idx_i,
	output arpc_scan_t       scan_o,
	output logic [IDX_W-1:0] match_idx_o,
	output logic [IDX_W-1:0] free_idx_o,
	output logic [IDX_W-1:0] old_idx_o
);

	logic        valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] stamp_q;

	logic             act_q;
	arpc_scan_t       scan_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] old_idx_q;

	logic [31:0] age;
	logic        is_match;
	logic        is_fresh;
	logic        take_old;
	arpc_scan_t  scan_d;

	assign age      = scan_i.now - stamp_q;
	assign is_match = valid_q && (ip_q == scan_i.ip);
	assign is_fresh = is_match && (age < {16'd0, age_limit});
	assign take_old = valid_q && (!scan_i.old_any || (age > scan_i.old_age));

	always_comb begin
		scan_d = scan_i;
		if (!scan_i.fresh && is_fresh) begin
			scan_d.fresh = 1'b1;
			scan_d.mac   = mac_q;
		end
		if (is_match) begin
			scan_d.match = 1'b1;
		end
		if (!valid_q) begin
			scan_d.free = 1'b1;
		end
		if (take_old) begin
			scan_d.old_any = 1'b1;
			scan_d.old_age = age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr_idx == CELL_IDX)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr_idx == CELL_IDX)) begin
			ip_q    <= wr.ip;
			mac_q   <= wr.mac;
			stamp_q <= wr.stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= scan_i.act;
		end
	end

	always_ff @(posedge clk) begin
		scan_q      <= scan_d;
		match_idx_q <= (!scan_i.match && is_match) ? CELL_IDX : match_idx_i;
		free_idx_q  <= (!scan_i.free && !valid_q) ? CELL_IDX : free_idx_i;
		old_idx_q   <= take_old ? CELL_IDX : old_idx_i;
	end

	always_comb begin
		scan_o     = scan_q;
		scan_o.act = act_q;
	end

	assign match_idx_o = match_idx_q;
	assign free_idx_o  = free_idx_q;
	assign old_idx_o   = old_idx_q;

endmodule

// ===== design/arp_cache_with_aging_unit.sv =====
// The scan record walks the row of entry cells one cell per cycle, and the table is
// written when it leaves; the result is registered after that. No request is taken
// during a scan, and a new request is taken once the previous result has been taken.
// Reset is asynchronous and active low; it empties the table at once and sets
// own_ip and own_mac to zero and age_limit to 6000.
module arp_cache_with_aging_unit
	import arpc_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [31:0] target_ip,
	input  logic [47:0] sender_mac,
	input  logic [15:0] ether_type,
	input  logic [15:0] arp_operation,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [47:0] found_mac,
	output logic        send_request,
	output logic        updated
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;
	logic [15:0] age_limit_q;

	arpc_state_t state_q, state_d;

	logic        func_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [15:0] etype_q;
	logic [15:0] op_q;
	logic [31:0] now_q;

	logic        out_valid_q;
	logic        hit_q;
	logic [47:0] found_mac_q;
	logic        send_request_q;
	logic        updated_q;

	arpc_scan_t       scan_w      [TABLE_ENTRIES+1];
	logic [IDX_W-1:0] match_idx_w [TABLE_ENTRIES+1];
	logic [IDX_W-1:0] free_idx_w  [TABLE_ENTRIES+1];
	logic [IDX_W-1:0] old_idx_w   [TABLE_ENTRIES+1];

	arpc_scan_t       tail;
	logic [IDX_W-1:0] slot;
	arpc_wr_t         wr;
	logic             accept;
	logic             done;
	logic             own_hit;
	logic             learn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q    <= '0;
			own_mac_q   <= '0;
			age_limit_q <= AGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_IP:    own_ip_q    <= cfg_data[31:0];
				CFG_OWN_MAC:   own_mac_q   <= cfg_data;
				CFG_AGE_LIMIT: age_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	always_comb begin
		scan_w[0]         = '0;
		scan_w[0].act     = accept;
		scan_w[0].ip      = target_ip;
		scan_w[0].now     = now;
		match_idx_w[0]    = '0;
		free_idx_w[0]     = '0;
		old_idx_w[0]      = '0;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		arpc_cell #(
			.IDX_W    (IDX_W),
			.CELL_IDX (IDX_W'(i))
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.age_limit   (age_limit_q),
			.wr          (wr),
			.wr_idx      (slot),
			.scan_i      (scan_w[i]),
			.match_idx_i (match_idx_w[i]),
			.free_idx_i  (free_idx_w[i]),
			.old_idx_i   (old_idx_w[i]),
			.scan_o      (scan_w[i+1]),
			.match_idx_o (match_idx_w[i+1]),
			.free_idx_o  (free_idx_w[i+1]),
			.old_idx_o   (old_idx_w[i+1])
		);
	end

	assign tail    = scan_w[TABLE_ENTRIES];
	assign done    = (state_q == ST_SCAN) && tail.act;
	assign own_hit = (ip_q == own_ip_q);
	assign learn   = (func_q == FUNC_FRAME) && (etype_q == ETHER_ARP) &&
	                 (op_q == OP_REPLY) && !own_hit;

	always_comb begin
		if (tail.match) begin
			slot = match_idx_w[TABLE_ENTRIES];
		end else if (tail.free) begin
			slot = free_idx_w[TABLE_ENTRIES];
		end else begin
			slot = old_idx_w[TABLE_ENTRIES];
		end
	end

	always_comb begin
		wr.en    = done && learn;
		wr.ip    = ip_q;
		wr.mac   = mac_q;
		wr.stamp = now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tail.act) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			ip_q    <= target_ip;
			mac_q   <= sender_mac;
			etype_q <= ether_type;
			op_q    <= arp_operation;
			now_q   <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			if (func_q == FUNC_LOOKUP) begin
				if (own_hit) begin
					hit_q          <= 1'b1;
					found_mac_q    <= own_mac_q;
					send_request_q <= 1'b0;
				end else begin
					hit_q          <= tail.fresh;
					found_mac_q    <= tail.fresh ? tail.mac : '0;
					send_request_q <= !tail.fresh;
				end
				updated_q <= 1'b0;
			end else begin
				hit_q          <= 1'b0;
				found_mac_q    <= '0;
				send_request_q <= 1'b0;
				updated_q      <= learn;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign found_mac    = found_mac_q;
	assign send_request = send_request_q;
	assign updated      = updated_q;

endmodule

// ===== design/arpc_checker.sv =====
`include "arp_cache_with_aging_unit_macros.svh"

module arpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        hit,
	input logic [47:0] found_mac,
	input logic        send_request,
	input logic        updated
);

	`ARPC_ASSERT(a_hit_xor_req, out_valid |-> !(hit && send_request), "Hit and request both set.")
	`ARPC_ASSERT(a_upd_alone, out_valid && updated |-> !hit && !send_request, "Update with lookup flags.")
	`ARPC_ASSERT(a_miss_zero_mac, out_valid && !hit |-> found_mac == 48'd0, "MAC not zero on a miss.")
	`ARPC_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "Request taken during a scan.")
	`ARPC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "Result shown during reset.")

endmodule

bind arp_cache_with_aging_unit arpc_checker u_arpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hit          (hit),
	.found_mac    (found_mac),
	.send_request (send_request),
	.updated      (updated)
);
